// ----- hw/rtl/lrc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRC tokenizer package
// Shared types, codes and character constants of the LRC lyric tokenizer.
// ----------------------------------------------------------------------------
package lrc_pkg;

	localparam int unsigned LEN_W  = 12;
	localparam int unsigned LINE_W = 24;
	localparam int unsigned COL_W  = 16;

	localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 12'd255;
	localparam logic [LINE_W-1:0] LINE_MAX      = 24'hFF_FFFF;
	localparam logic [COL_W-1:0]  COL_MAX       = 16'hFFFF;

	// characters that steer the parse
	localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
	localparam logic [7:0] CH_RBRACK = 8'h5D; // ']'
	localparam logic [7:0] CH_COLON  = 8'h3A; // ':'
	localparam logic [7:0] CH_DOT    = 8'h2E; // '.'
	localparam logic [7:0] CH_LF     = 8'h0A; // newline
	localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CH_NINE   = 8'h39; // '9'

	// parser states, one-hot
	typedef enum logic [7:0] {
		ST_START     = 8'b0000_0001,
		ST_TAG       = 8'b0000_0010,
		ST_TAG_NAME  = 8'b0000_0100,
		ST_TAG_VALUE = 8'b0000_1000,
		ST_TIME      = 8'b0001_0000,
		ST_LYRIC     = 8'b0010_0000,
		ST_COMMENT   = 8'b0100_0000,
		ST_DONE      = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		ROLE_MARKUP    = 3'd0,
		ROLE_TAG_NAME  = 3'd1,
		ROLE_TAG_VALUE = 3'd2,
		ROLE_TIME      = 3'd3,
		ROLE_LYRIC     = 3'd4
	} role_t;

	typedef enum logic [2:0] {
		FEND_NONE     = 3'd0,
		FEND_TAG_NAME = 3'd1,
		FEND_TAG      = 3'd2,
		FEND_TIME     = 3'd3,
		FEND_LYRIC    = 3'd4
	} fend_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CHAR     = 2'd1,
		ERR_OVERFLOW = 2'd2,
		ERR_STATE    = 2'd3
	} err_t;

	// one result beat, from the parser to the output register
	typedef struct packed {
		role_t             role;
		fend_t             field_end;
		err_t              error_code;
		logic [LINE_W-1:0] line_no;
		logic [COL_W-1:0]  col_no;
		logic              finished;
	} result_t;

endpackage

// ----- hw/rtl/lrc_byte_if.sv -----
// ----------------------------------------------------------------------------
// LRC byte channel
// Valid/ready channel carrying one text byte and the end-of-text flag.
// ----------------------------------------------------------------------------
interface lrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_text;

	modport source (output valid, output ch, output end_of_text, input ready);
	modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

// ----- hw/rtl/lrc_token_if.sv -----
// ----------------------------------------------------------------------------
// LRC token channel
// Valid/ready channel carrying the classification of one text byte.
// ----------------------------------------------------------------------------
interface lrc_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  role;
	logic [2:0]  field_end;
	logic [1:0]  error_code;
	logic [23:0] line_no;
	logic [15:0] col_no;
	logic        finished;

	modport source (output valid, output role, output field_end, output error_code,
		output line_no, output col_no, output finished, input ready);
	modport sink   (input valid, input role, input field_end, input error_code,
		input line_no, input col_no, input finished, output ready);
endinterface

// ----- hw/rtl/lrc_lyric_tokenizer.sv -----
// ----------------------------------------------------------------------------
// LRC lyric tokenizer
// Classifies each byte of an LRC lyrics text and tracks line, column and error.
// ----------------------------------------------------------------------------
// The block takes one text byte per beat and returns one token beat for each:
// the byte's role, any field it closes, a sticky error, line and column, and
// a finished flag. It can accept a byte every cycle while its results are
// taken. The parse state advances once per byte and each result is registered,
// so it appears in the cycle after its byte. A byte is taken while the output
// register is empty or its result leaves in the same cycle, so a stalled result
// holds off new bytes until it is taken. Write max_field_len through
// cfg_we/cfg_wdata only while no beat is in flight.
module lrc_lyric_tokenizer (
	input  logic                      clk,
	input  logic                      arst_n,
	lrc_byte_if.sink                  bytes,
	lrc_token_if.source               tokens,
	input  logic                      cfg_we,
	input  logic [lrc_pkg::LEN_W-1:0] cfg_wdata
);

	logic             accept;
	logic             vld_q;
	lrc_pkg::result_t res_next;
	lrc_pkg::result_t res_q;

	// take a byte when the output register is empty or being drained
	assign bytes.ready = !vld_q || tokens.ready;
	assign accept      = bytes.valid && bytes.ready;

	lrc_parse_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.ch          (bytes.ch),
		.end_of_text (bytes.end_of_text),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.res         (res_next)
	);

	// hold the valid flag of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (tokens.ready) begin
			vld_q <= 1'b0;
		end
	end

	// load the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign tokens.valid      = vld_q;
	assign tokens.role       = res_q.role;
	assign tokens.field_end  = res_q.field_end;
	assign tokens.error_code = res_q.error_code;
	assign tokens.line_no    = res_q.line_no;
	assign tokens.col_no     = res_q.col_no;
	assign tokens.finished   = res_q.finished;

endmodule

// ----- hw/rtl/lrc_parse_fsm.sv -----
// ----------------------------------------------------------------------------
// LRC parse state machine
// Holds the parse state, counters and field limit; computes the result of
// one byte combinationally and advances the state when step is high.
// ----------------------------------------------------------------------------
module lrc_parse_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [7:0]                     ch,
	input  logic                           end_of_text,
	input  logic                           cfg_we,
	input  logic [lrc_pkg::LEN_W-1:0]      cfg_wdata,
	output lrc_pkg::result_t               res
);

	lrc_pkg::state_t               st_q, st_d;
	lrc_pkg::err_t                 err_q, err_d;
	logic [lrc_pkg::LINE_W-1:0]    line_q, line_d;
	logic [lrc_pkg::COL_W-1:0]     col_q, col_d;
	logic [lrc_pkg::LEN_W-1:0]     flen_q, flen_d;
	logic [lrc_pkg::LEN_W-1:0]     max_len_q;

	logic [7:0]       c;
	logic             nl;
	logic             is_dig;
	logic             ovf_grow;   // next character of a running field overflows
	logic             ovf_first;  // first character of a new field overflows
	lrc_pkg::role_t   role;
	lrc_pkg::fend_t   fend;

	// field limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lrc_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	assign c         = end_of_text ? lrc_pkg::CH_LF : ch;
	assign nl        = (c == lrc_pkg::CH_LF);
	assign is_dig    = c inside {[lrc_pkg::CH_ZERO:lrc_pkg::CH_NINE]};
	assign ovf_grow  = (flen_q >= max_len_q);
	assign ovf_first = (max_len_q == '0);

	// next state and result of one byte
	always_comb begin
		st_d   = st_q;
		err_d  = err_q;
		line_d = line_q;
		col_d  = col_q;
		flen_d = flen_q;
		role   = lrc_pkg::ROLE_MARKUP;
		fend   = lrc_pkg::FEND_NONE;

		if (st_q != lrc_pkg::ST_DONE) begin
			// advance line and column, saturating
			if (nl) begin
				col_d = '0;
				if (line_q < lrc_pkg::LINE_MAX) begin
					line_d = line_q + 1'b1;
				end
			end else if (col_q < lrc_pkg::COL_MAX) begin
				col_d = col_q + 1'b1;
			end

			case (st_q)
				lrc_pkg::ST_START: begin
					if (c == lrc_pkg::CH_LBRACK) begin
						st_d = lrc_pkg::ST_TAG;
					end else if (!nl) begin
						// untagged lyric line keeps its first character
						st_d = lrc_pkg::ST_LYRIC;
						if (ovf_first) begin
							err_d  = lrc_pkg::ERR_OVERFLOW;
							flen_d = '0;
						end else begin
							flen_d = lrc_pkg::LEN_W'(1);
							role   = lrc_pkg::ROLE_LYRIC;
						end
					end
				end
				lrc_pkg::ST_TAG: begin
					if (nl) begin
						err_d = lrc_pkg::ERR_CHAR;
					end else begin
						st_d = is_dig ? lrc_pkg::ST_TIME : lrc_pkg::ST_TAG_NAME;
						if (ovf_first) begin
							err_d  = lrc_pkg::ERR_OVERFLOW;
							flen_d = '0;
						end else begin
							flen_d = lrc_pkg::LEN_W'(1);
							role   = is_dig ? lrc_pkg::ROLE_TIME : lrc_pkg::ROLE_TAG_NAME;
						end
					end
				end
				lrc_pkg::ST_TAG_NAME: begin
					if (c == lrc_pkg::CH_COLON) begin
						flen_d = '0;
						st_d   = lrc_pkg::ST_TAG_VALUE;
						fend   = lrc_pkg::FEND_TAG_NAME;
					end else if (c == lrc_pkg::CH_RBRACK || nl) begin
						err_d = lrc_pkg::ERR_CHAR;
					end else if (ovf_grow) begin
						err_d = lrc_pkg::ERR_OVERFLOW;
					end else begin
						flen_d = flen_q + 1'b1;
						role   = lrc_pkg::ROLE_TAG_NAME;
					end
				end
				lrc_pkg::ST_TAG_VALUE: begin
					if (c == lrc_pkg::CH_RBRACK) begin
						flen_d = '0;
						st_d   = lrc_pkg::ST_COMMENT;
						fend   = lrc_pkg::FEND_TAG;
					end else if (nl) begin
						err_d = lrc_pkg::ERR_CHAR;
					end else if (ovf_grow) begin
						err_d = lrc_pkg::ERR_OVERFLOW;
					end else begin
						flen_d = flen_q + 1'b1;
						role   = lrc_pkg::ROLE_TAG_VALUE;
					end
				end
				lrc_pkg::ST_TIME: begin
					if (c == lrc_pkg::CH_RBRACK) begin
						flen_d = '0;
						st_d   = lrc_pkg::ST_LYRIC;
						fend   = lrc_pkg::FEND_TIME;
					end else if (is_dig || c == lrc_pkg::CH_COLON || c == lrc_pkg::CH_DOT) begin
						if (ovf_grow) begin
							err_d = lrc_pkg::ERR_OVERFLOW;
						end else begin
							flen_d = flen_q + 1'b1;
							role   = lrc_pkg::ROLE_TIME;
						end
					end else begin
						err_d = lrc_pkg::ERR_CHAR;
					end
				end
				lrc_pkg::ST_LYRIC: begin
					if (nl) begin
						flen_d = '0;
						st_d   = lrc_pkg::ST_START;
						fend   = lrc_pkg::FEND_LYRIC;
					end else if (ovf_grow) begin
						err_d = lrc_pkg::ERR_OVERFLOW;
					end else begin
						flen_d = flen_q + 1'b1;
						role   = lrc_pkg::ROLE_LYRIC;
					end
				end
				lrc_pkg::ST_COMMENT: begin
					if (nl) begin
						st_d = lrc_pkg::ST_START;
					end
				end
				default: begin
					err_d = lrc_pkg::ERR_STATE;
				end
			endcase

			// any error ends the parse and masks the byte
			if (err_d != lrc_pkg::ERR_NONE) begin
				role = lrc_pkg::ROLE_MARKUP;
				fend = lrc_pkg::FEND_NONE;
				st_d = lrc_pkg::ST_DONE;
			end
			if (end_of_text) begin
				st_d = lrc_pkg::ST_DONE;
			end
		end
	end

	// state registers, advanced once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= lrc_pkg::ST_START;
			err_q  <= lrc_pkg::ERR_NONE;
			line_q <= lrc_pkg::LINE_W'(1);
			col_q  <= '0;
			flen_q <= '0;
		end else if (step) begin
			st_q   <= st_d;
			err_q  <= err_d;
			line_q <= line_d;
			col_q  <= col_d;
			flen_q <= flen_d;
		end
	end

	// result of the byte on the inputs
	always_comb begin
		res.role       = role;
		res.field_end  = fend;
		res.error_code = err_d;
		res.line_no    = line_d;
		res.col_no     = col_d;
		res.finished   = (st_d == lrc_pkg::ST_DONE);
	end

`ifndef NO_ASSERTIONS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == lrc_pkg::ST_DONE |=> st_q == lrc_pkg::ST_DONE)
		else $error("parse left the done state");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != lrc_pkg::ERR_NONE |-> st_q == lrc_pkg::ST_DONE)
		else $error("error raised while parse still running");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count reached zero");

	a_col_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && nl && st_q != lrc_pkg::ST_DONE |=> col_q == '0)
		else $error("column not cleared after newline");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg_we && st_q != lrc_pkg::ST_DONE |=> flen_q <= max_len_q)
		else $error("field length passed the limit");
`endif

endmodule
